// ----- src/twot_pkg.sv -----
// twot_pkg: shared types, constants and the arctangent table for the
// three-wheel odometry tracker. No dependencies.
package twot_pkg;

	localparam int CW = 34;
	localparam int MAG_W = 40;
	localparam int DIV_N = 64;
	localparam int DIV_D = 38;

	localparam logic [34:0] TWO_PI_U = 35'd105414357;
	localparam logic signed [CW-1:0] TWO_PI_S = 34'sd105414357;
	localparam logic signed [CW-1:0] PI_Q24 = 34'sd52707179;
	localparam logic signed [CW-1:0] HALF_PI_Q24 = 34'sd26353589;
	localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

	typedef enum logic [1:0] {
		CFG_IPT = 2'd0,
		CFG_LOFF = 2'd1,
		CFG_ROFF = 2'd2,
		CFG_BOFF = 2'd3
	} cfg_idx_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_ML, ST_MR, ST_MB, ST_DIV_TH, ST_CS_H, ST_M_RD, ST_D_R, ST_M_RO,
		ST_M_BD, ST_D_B, ST_M_BO, ST_CS_G, ST_M_XS, ST_M_XC, ST_M_YC, ST_M_YS, ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		CS_IDLE, CS_RED, CS_FOLD, CS_ROT, CS_FIN
	} cs_state_t;

	typedef struct packed {
		logic start;
		logic signed [CW-1:0] phi;
	} cs_req_t;

	typedef struct packed {
		logic done;
		logic signed [CW-1:0] sn;
		logic signed [CW-1:0] cs;
	} cs_rsp_t;

	function automatic logic [30:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0: atan_q30 = 31'd843314857;
			5'd1: atan_q30 = 31'd497837829;
			5'd2: atan_q30 = 31'd263043837;
			5'd3: atan_q30 = 31'd133525159;
			5'd4: atan_q30 = 31'd67021687;
			5'd5: atan_q30 = 31'd33543516;
			5'd6: atan_q30 = 31'd16775851;
			5'd7: atan_q30 = 31'd8388437;
			5'd8: atan_q30 = 31'd4194283;
			5'd9: atan_q30 = 31'd2097149;
			default: atan_q30 = 31'd1 << (5'd30 - i);
		endcase
	endfunction

endpackage

// ----- src/twot_cordic.sv -----
// twot_cordic: iterative sine/cosine in Q2.30 of a Q8.24 angle, with
// bit-serial reduction modulo 2*pi. Depends on twot_pkg.
module twot_cordic #(
	parameter int STEPS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  twot_pkg::cs_req_t req,
	output twot_pkg::cs_rsp_t rsp
);

	twot_pkg::cs_state_t state_q, state_d;
	logic [twot_pkg::CW-1:0] mag_q;
	logic neg_q, flip_q;
	logic [2:0] k_q;
	logic [4:0] i_q;
	logic signed [twot_pkg::CW-1:0] x_q, y_q, z_q;

	logic [34:0] red_cmp, red_sub;
	logic red_ge;
	logic signed [twot_pkg::CW-1:0] r0, r1, r2, r3;
	logic flip_d;
	logic signed [twot_pkg::CW-1:0] xs, ys, atn;

	assign red_cmp = twot_pkg::TWO_PI_U << k_q;
	assign red_ge = {1'b0, mag_q} >= red_cmp;
	assign red_sub = {1'b0, mag_q} - red_cmp;

	always_comb begin
		r0 = neg_q ? -$signed(mag_q) : $signed(mag_q);
		r1 = (r0 >= twot_pkg::PI_Q24) ? r0 - twot_pkg::TWO_PI_S : r0;
		r2 = (r1 < -twot_pkg::PI_Q24) ? r1 + twot_pkg::TWO_PI_S : r1;
		flip_d = 1'b0;
		r3 = r2;
		if (r2 > twot_pkg::HALF_PI_Q24) begin
			r3 = twot_pkg::PI_Q24 - r2;
			flip_d = 1'b1;
		end else if (r2 < -twot_pkg::HALF_PI_Q24) begin
			r3 = -twot_pkg::PI_Q24 - r2;
			flip_d = 1'b1;
		end
	end

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign atn = $signed({3'b000, twot_pkg::atan_q30(i_q)});

	always_comb begin
		state_d = state_q;
		rsp.done = 1'b0;
		rsp.sn = y_q;
		rsp.cs = flip_q ? -x_q : x_q;
		unique case (state_q)
			twot_pkg::CS_IDLE: if (req.start) state_d = twot_pkg::CS_RED;
			twot_pkg::CS_RED: if (k_q == 3'd0) state_d = twot_pkg::CS_FOLD;
			twot_pkg::CS_FOLD: state_d = twot_pkg::CS_ROT;
			twot_pkg::CS_ROT: if (i_q == 5'(STEPS - 1)) state_d = twot_pkg::CS_FIN;
			twot_pkg::CS_FIN: begin
				rsp.done = 1'b1;
				state_d = twot_pkg::CS_IDLE;
			end
			default: state_d = twot_pkg::CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twot_pkg::CS_IDLE;
			k_q <= 3'd0;
			i_q <= 5'd0;
		end else begin
			state_q <= state_d;
			if (state_q == twot_pkg::CS_IDLE) begin
				k_q <= 3'd7;
				i_q <= 5'd0;
			end else if (state_q == twot_pkg::CS_RED) begin
				k_q <= k_q - 3'd1;
			end else if (state_q == twot_pkg::CS_ROT) begin
				i_q <= i_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == twot_pkg::CS_IDLE && req.start) begin
			neg_q <= req.phi[twot_pkg::CW-1];
			mag_q <= req.phi[twot_pkg::CW-1] ? 34'(-req.phi) : req.phi;
		end
		if (state_q == twot_pkg::CS_RED && red_ge)
			mag_q <= red_sub[twot_pkg::CW-1:0];
		if (state_q == twot_pkg::CS_FOLD) begin
			flip_q <= flip_d;
			z_q <= r3 <<< 6;
			x_q <= twot_pkg::GAIN_Q30;
			y_q <= '0;
		end
		if (state_q == twot_pkg::CS_ROT) begin
			if (!z_q[twot_pkg::CW-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atn;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atn;
			end
		end
	end

endmodule

// ----- src/three_wheel_odometry_tracker_core.sv -----
// three_wheel_odometry_tracker_core: top level of the arc odometry tracker.
// Depends on twot_pkg and twot_cordic.
//
// Usage:
//   Input channel (in_valid/in_stall): one beat carries op and the three raw
//   encoder counts. op = 1 clears pose and previous counts; op = 0 updates.
//   Output channel (out_valid/out_stall): one beat per input beat with the
//   new pose (Q16.16 x/y, Q8.24 heading) and the fault flag.
//   Configuration channel (cfg_valid/cfg_ready): cfg_index selects
//   inch_per_tick, left, right or back offset; cfg_ready is always high.
//   Write it only while no item is in flight.
// Operation: one item at a time. A clear goes from idle straight to the output step.
//   An update runs a bit-serial multiplier (11 products), a radix-2 divider
//   (up to 3 divisions) and the CORDIC unit (up to twice), one step after
//   another; fewer steps run when the heading change is zero or the wheel
//   offsets sum to zero.
// The output register holds a result while out_stall is high; the next item
//   is accepted meanwhile and waits at its final step for the register.
// Reset clears the pose, previous counts and restores the register defaults.
module three_wheel_odometry_tracker_core #(
	parameter int COUNT_BITS = 32,
	parameter int CORDIC_STEPS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic signed [31:0] left_count,
	input  logic signed [31:0] right_count,
	input  logic signed [31:0] back_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] x_pos,
	output logic signed [31:0] y_pos,
	output logic signed [31:0] heading,
	output logic               fault,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	localparam int CB = COUNT_BITS;

	function automatic logic [32:0] sat32(input logic signed [95:0] v);
		if (v > 96'sd2147483647) sat32 = {1'b1, 32'h7fffffff};
		else if (v < -96'sd2147483648) sat32 = {1'b1, 32'h80000000};
		else sat32 = {1'b0, v[31:0]};
	endfunction

	twot_pkg::state_t state_q, state_d;
	logic ph_q, ph_d;

	logic [23:0] ipt_q, loff_q, roff_q, boff_q;
	logic [CB-1:0] prev_l_q, prev_r_q, prev_b_q, cur_l_q, cur_r_q, cur_b_q;
	logic signed [31:0] pos_x_q, pos_y_q, ang_q;
	logic signed [31:0] dl_q, dr_q, db_q, dth_q, h_q;
	logic signed [twot_pkg::CW-1:0] sh_q, sg_q, cg_q;
	logic signed [39:0] cr_q, cb_q;
	logic [63:0] tmp_q;
	logic tmp_neg_q;
	logic signed [52:0] xacc_q, yacc_q;
	logic clr_q, flt_q;
	logic out_valid_q, fault_q;
	logic signed [31:0] x_pos_q, y_pos_q, heading_q;

	// serial multiplier
	logic [twot_pkg::MAG_W-1:0] mul_a_q;
	logic [2*twot_pkg::MAG_W-1:0] mul_p_q;
	logic mul_neg_q;
	logic [5:0] mul_cnt_q;
	logic mul_done;
	logic [twot_pkg::MAG_W:0] mul_sum;
	logic signed [twot_pkg::MAG_W:0] mop_a, mop_b, mabs_a, mabs_b;
	logic signed [2*twot_pkg::MAG_W:0] prod;
	logic signed [95:0] prod96, prod_sh8, prod_sh30;

	// serial divider
	logic [twot_pkg::DIV_N-1:0] div_nq_q;
	logic [twot_pkg::DIV_D-1:0] div_r_q, div_d_q;
	logic div_neg_q;
	logic [6:0] div_cnt_q;
	logic div_done;
	logic [twot_pkg::DIV_D:0] rem_sh, rem_sub;
	logic rem_ge;
	logic [twot_pkg::DIV_N-1:0] dop_n;
	logic [twot_pkg::DIV_D-1:0] dop_d;
	logic dop_neg;
	logic signed [twot_pkg::DIV_N:0] quot;
	logic signed [95:0] quot96;

	logic unit_mul, unit_div, unit_cs, step_done, accept, out_free;
	logic mul_ld, div_ld;
	logic [CB-1:0] dlt_l, dlt_r, dlt_b;
	logic signed [32:0] ddiff, dmag;
	logic signed [32:0] dth_abs;
	logic [24:0] tw;
	logic signed [34:0] sh2;
	logic [32:0] sat_m, sat_q, sat_x, sat_y, sat_h;

	twot_pkg::cs_req_t cs_req;
	twot_pkg::cs_rsp_t cs_rsp;

	twot_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (cs_req),
		.rsp    (cs_rsp)
	);

	assign accept = (state_q == twot_pkg::ST_IDLE) && in_valid;
	assign in_stall = (state_q != twot_pkg::ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign x_pos = x_pos_q;
	assign y_pos = y_pos_q;
	assign heading = heading_q;
	assign fault = fault_q;

	assign dlt_l = cur_l_q - prev_l_q;
	assign dlt_r = cur_r_q - prev_r_q;
	assign dlt_b = cur_b_q - prev_b_q;
	assign tw = {1'b0, loff_q} + {1'b0, roff_q};
	assign ddiff = 33'(dr_q) - 33'(dl_q);
	assign dmag = ddiff[32] ? -ddiff : ddiff;
	assign dth_abs = dth_q[31] ? -33'(dth_q) : 33'(dth_q);
	assign sh2 = {sh_q[twot_pkg::CW-1], sh_q} <<< 1;

	always_comb begin
		unit_mul = 1'b0;
		unit_div = 1'b0;
		unit_cs = 1'b0;
		unique case (state_q) inside
			twot_pkg::ST_ML, twot_pkg::ST_MR, twot_pkg::ST_MB, twot_pkg::ST_M_RD,
			twot_pkg::ST_M_RO, twot_pkg::ST_M_BD, twot_pkg::ST_M_BO, twot_pkg::ST_M_XS,
			twot_pkg::ST_M_XC, twot_pkg::ST_M_YC, twot_pkg::ST_M_YS: unit_mul = 1'b1;
			twot_pkg::ST_DIV_TH, twot_pkg::ST_D_R, twot_pkg::ST_D_B: unit_div = 1'b1;
			twot_pkg::ST_CS_H, twot_pkg::ST_CS_G: unit_cs = 1'b1;
			default: ;
		endcase
	end

	assign mul_done = (mul_cnt_q == 6'(twot_pkg::MAG_W));
	assign div_done = (div_cnt_q == 7'(twot_pkg::DIV_N));
	assign step_done = ph_q && ((unit_mul && mul_done) || (unit_div && div_done) ||
		(unit_cs && cs_rsp.done));
	assign mul_ld = unit_mul && !ph_q;
	assign div_ld = unit_div && !ph_q;

	always_comb begin
		state_d = state_q;
		ph_d = ph_q;
		if ((unit_mul || unit_div || unit_cs) && !ph_q) ph_d = 1'b1;
		if (step_done) ph_d = 1'b0;
		unique case (state_q)
			twot_pkg::ST_IDLE: if (in_valid) state_d = op ? twot_pkg::ST_OUT : twot_pkg::ST_ML;
			twot_pkg::ST_ML: if (step_done) state_d = twot_pkg::ST_MR;
			twot_pkg::ST_MR: if (step_done) state_d = twot_pkg::ST_MB;
			twot_pkg::ST_MB:
				if (step_done) state_d = (tw == 25'd0) ? twot_pkg::ST_CS_G : twot_pkg::ST_DIV_TH;
			twot_pkg::ST_DIV_TH:
				if (step_done)
					state_d = (div_nq_q == '0) ? twot_pkg::ST_CS_G : twot_pkg::ST_CS_H;
			twot_pkg::ST_CS_H: if (step_done) state_d = twot_pkg::ST_M_RD;
			twot_pkg::ST_M_RD: if (step_done) state_d = twot_pkg::ST_D_R;
			twot_pkg::ST_D_R: if (step_done) state_d = twot_pkg::ST_M_RO;
			twot_pkg::ST_M_RO: if (step_done) state_d = twot_pkg::ST_M_BD;
			twot_pkg::ST_M_BD: if (step_done) state_d = twot_pkg::ST_D_B;
			twot_pkg::ST_D_B: if (step_done) state_d = twot_pkg::ST_M_BO;
			twot_pkg::ST_M_BO: if (step_done) state_d = twot_pkg::ST_CS_G;
			twot_pkg::ST_CS_G: if (step_done) state_d = twot_pkg::ST_M_XS;
			twot_pkg::ST_M_XS: if (step_done) state_d = twot_pkg::ST_M_XC;
			twot_pkg::ST_M_XC: if (step_done) state_d = twot_pkg::ST_M_YC;
			twot_pkg::ST_M_YC: if (step_done) state_d = twot_pkg::ST_M_YS;
			twot_pkg::ST_M_YS: if (step_done) state_d = twot_pkg::ST_OUT;
			twot_pkg::ST_OUT: if (out_free) state_d = twot_pkg::ST_IDLE;
			default: state_d = twot_pkg::ST_IDLE;
		endcase
	end

	// operand selection
	always_comb begin
		mop_a = '0;
		mop_b = '0;
		case (state_q)
			twot_pkg::ST_ML: begin
				mop_a = 41'(signed'(dlt_l));
				mop_b = $signed({17'd0, ipt_q});
			end
			twot_pkg::ST_MR: begin
				mop_a = 41'(signed'(dlt_r));
				mop_b = $signed({17'd0, ipt_q});
			end
			twot_pkg::ST_MB: begin
				mop_a = 41'(signed'(dlt_b));
				mop_b = $signed({17'd0, ipt_q});
			end
			twot_pkg::ST_M_RD: begin
				mop_a = 41'(dr_q);
				mop_b = 41'(sh2);
			end
			twot_pkg::ST_M_RO: begin
				mop_a = $signed({17'd0, roff_q});
				mop_b = 41'(sh2);
			end
			twot_pkg::ST_M_BD: begin
				mop_a = 41'(db_q);
				mop_b = 41'(sh2);
			end
			twot_pkg::ST_M_BO: begin
				mop_a = $signed({17'd0, boff_q});
				mop_b = 41'(sh2);
			end
			twot_pkg::ST_M_XS: begin
				mop_a = 41'(cr_q);
				mop_b = 41'(sg_q);
			end
			twot_pkg::ST_M_XC: begin
				mop_a = 41'(cb_q);
				mop_b = 41'(cg_q);
			end
			twot_pkg::ST_M_YC: begin
				mop_a = 41'(cr_q);
				mop_b = 41'(cg_q);
			end
			twot_pkg::ST_M_YS: begin
				mop_a = 41'(cb_q);
				mop_b = 41'(sg_q);
			end
			default: ;
		endcase
		mabs_a = mop_a[twot_pkg::MAG_W] ? -mop_a : mop_a;
		mabs_b = mop_b[twot_pkg::MAG_W] ? -mop_b : mop_b;
	end

	always_comb begin
		dop_n = {7'd0, dmag, 24'd0};
		dop_d = {13'd0, tw};
		dop_neg = ddiff[32];
		if (state_q != twot_pkg::ST_DIV_TH) begin
			dop_n = tmp_q;
			dop_d = {dth_abs[31:0], 6'd0};
			dop_neg = tmp_neg_q ^ dth_q[31];
		end
	end

	assign mul_sum = {1'b0, mul_p_q[2*twot_pkg::MAG_W-1:twot_pkg::MAG_W]} +
		(mul_p_q[0] ? {1'b0, mul_a_q} : '0);
	assign prod = mul_neg_q ? -$signed({1'b0, mul_p_q}) : $signed({1'b0, mul_p_q});
	assign prod96 = 96'(prod);
	assign prod_sh8 = prod96 >>> 8;
	assign prod_sh30 = prod96 >>> 30;

	assign rem_sh = {div_r_q, div_nq_q[twot_pkg::DIV_N-1]};
	assign rem_ge = rem_sh >= {1'b0, div_d_q};
	assign rem_sub = rem_sh - {1'b0, div_d_q};
	assign quot = div_neg_q ? -$signed({1'b0, div_nq_q}) : $signed({1'b0, div_nq_q});
	assign quot96 = 96'(quot);

	assign sat_m = sat32(prod_sh8);
	assign sat_q = sat32(quot96);
	assign sat_x = sat32(96'(xacc_q));
	assign sat_y = sat32(96'(yacc_q));
	assign sat_h = sat32(96'(33'(ang_q) + 33'(dth_q)));

	assign cs_req.start = unit_cs && !ph_q;
	assign cs_req.phi = (state_q == twot_pkg::ST_CS_H) ? 34'(h_q) : 34'(ang_q) + 34'(h_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twot_pkg::ST_IDLE;
			ph_q <= 1'b0;
			mul_cnt_q <= 6'(twot_pkg::MAG_W);
			div_cnt_q <= 7'(twot_pkg::DIV_N);
			out_valid_q <= 1'b0;
			ipt_q <= 24'd402653;
			loff_q <= 24'd327680;
			roff_q <= 24'd327680;
			boff_q <= 24'd327680;
			prev_l_q <= '0;
			prev_r_q <= '0;
			prev_b_q <= '0;
			pos_x_q <= '0;
			pos_y_q <= '0;
			ang_q <= '0;
		end else begin
			state_q <= state_d;
			ph_q <= ph_d;
			if (mul_ld) mul_cnt_q <= '0;
			else if (!mul_done) mul_cnt_q <= mul_cnt_q + 6'd1;
			if (div_ld) div_cnt_q <= '0;
			else if (!div_done) div_cnt_q <= div_cnt_q + 7'd1;
			if (cfg_valid) begin
				unique case (twot_pkg::cfg_idx_t'(cfg_index))
					twot_pkg::CFG_IPT: ipt_q <= cfg_data;
					twot_pkg::CFG_LOFF: loff_q <= cfg_data;
					twot_pkg::CFG_ROFF: roff_q <= cfg_data;
					twot_pkg::CFG_BOFF: boff_q <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == twot_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
				if (clr_q) begin
					prev_l_q <= '0;
					prev_r_q <= '0;
					prev_b_q <= '0;
					pos_x_q <= '0;
					pos_y_q <= '0;
					ang_q <= '0;
				end else begin
					prev_l_q <= cur_l_q;
					prev_r_q <= cur_r_q;
					prev_b_q <= cur_b_q;
					pos_x_q <= sat_x[31:0];
					pos_y_q <= sat_y[31:0];
					ang_q <= sat_h[31:0];
				end
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			clr_q <= op;
			flt_q <= 1'b0;
			cur_l_q <= left_count[CB-1:0];
			cur_r_q <= right_count[CB-1:0];
			cur_b_q <= back_count[CB-1:0];
		end
		if (mul_ld) begin
			mul_a_q <= mabs_a[twot_pkg::MAG_W-1:0];
			mul_p_q <= {{twot_pkg::MAG_W{1'b0}}, mabs_b[twot_pkg::MAG_W-1:0]};
			mul_neg_q <= mop_a[twot_pkg::MAG_W] ^ mop_b[twot_pkg::MAG_W];
		end else if (!mul_done) begin
			mul_p_q <= {mul_sum, mul_p_q[twot_pkg::MAG_W-1:1]};
		end
		if (div_ld) begin
			div_nq_q <= dop_n;
			div_d_q <= dop_d;
			div_r_q <= '0;
			div_neg_q <= dop_neg;
		end else if (!div_done) begin
			div_r_q <= rem_ge ? rem_sub[twot_pkg::DIV_D-1:0] : rem_sh[twot_pkg::DIV_D-1:0];
			div_nq_q <= {div_nq_q[twot_pkg::DIV_N-2:0], rem_ge};
		end
		if (step_done) begin
			case (state_q)
				twot_pkg::ST_ML: begin
					dl_q <= sat_m[31:0];
					flt_q <= flt_q | sat_m[32];
				end
				twot_pkg::ST_MR: begin
					dr_q <= sat_m[31:0];
					flt_q <= flt_q | sat_m[32];
				end
				twot_pkg::ST_MB: begin
					db_q <= sat_m[31:0];
					flt_q <= flt_q | sat_m[32] | (tw == 25'd0);
					dth_q <= '0;
					h_q <= '0;
					cr_q <= 40'(dr_q);
					cb_q <= 40'(signed'(sat_m[31:0]));
				end
				twot_pkg::ST_DIV_TH: begin
					dth_q <= sat_q[31:0];
					h_q <= {sat_q[31], sat_q[31:1]};
					flt_q <= flt_q | sat_q[32];
				end
				twot_pkg::ST_CS_H: sh_q <= cs_rsp.sn;
				twot_pkg::ST_M_RD, twot_pkg::ST_M_BD: begin
					tmp_q <= mul_p_q[63:0];
					tmp_neg_q <= mul_neg_q;
				end
				twot_pkg::ST_D_R: cr_q <= quot[39:0];
				twot_pkg::ST_M_RO: cr_q <= cr_q + prod_sh30[39:0];
				twot_pkg::ST_D_B: cb_q <= quot[39:0];
				twot_pkg::ST_M_BO: cb_q <= cb_q + prod_sh30[39:0];
				twot_pkg::ST_CS_G: begin
					sg_q <= cs_rsp.sn;
					cg_q <= cs_rsp.cs;
				end
				twot_pkg::ST_M_XS: xacc_q <= 53'(pos_x_q) + prod_sh30[52:0];
				twot_pkg::ST_M_XC: xacc_q <= xacc_q + prod_sh30[52:0];
				twot_pkg::ST_M_YC: yacc_q <= 53'(pos_y_q) + prod_sh30[52:0];
				twot_pkg::ST_M_YS: yacc_q <= yacc_q - prod_sh30[52:0];
				default: ;
			endcase
		end
		if (state_q == twot_pkg::ST_OUT && out_free) begin
			if (clr_q) begin
				x_pos_q <= '0;
				y_pos_q <= '0;
				heading_q <= '0;
				fault_q <= 1'b0;
			end else begin
				x_pos_q <= sat_x[31:0];
				y_pos_q <= sat_y[31:0];
				heading_q <= sat_h[31:0];
				fault_q <= flt_q | sat_x[32] | sat_y[32] | sat_h[32];
			end
		end
	end

endmodule

// ----- src/twot_chk.sv -----
// twot_chk: port-level assertions for the odometry tracker top level,
// bound to three_wheel_odometry_tracker_core.
module twot_chk (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [31:0] x_pos,
	input logic signed [31:0] heading
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(x_pos) && $stable(heading))
		else $error("stalled output beat changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second beat accepted before the first finished");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result appeared the cycle after accept");

endmodule

bind three_wheel_odometry_tracker_core twot_chk u_twot_chk (.*);
